@@ design/aaie_pkg.sv @@
// Package for the accumulator ALU execute block: widths, codes and item layout.
package aaie_pkg;

    // Byte memory address width and depth
    localparam int ADDR_BITS = 16;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    // Stream item widths
    localparam int S_DATA_BITS = 48;
    localparam int S_USER_BITS = 2;
    localparam int M_DATA_BITS = 40;

    typedef logic [ADDR_BITS-1:0] addr_t;

    // Item kind carried on tuser
    typedef enum logic [1:0] {
        MODE_EXEC  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    // Function field, opcode bits 6:4
    typedef enum logic [2:0] {
        FN_AND = 3'd0,
        FN_OR  = 3'd1,
        FN_XOR = 3'd2,
        FN_ADD = 3'd3,
        FN_SUB = 3'd4,
        FN_INC = 3'd5,
        FN_DEC = 3'd6,
        FN_NOT = 3'd7
    } fn_t;

    // Destination field, opcode bits 3:2
    typedef enum logic [1:0] {
        DST_MEM_MAR = 2'd0,
        DST_ACC     = 2'd1,
        DST_MAR     = 2'd2,
        DST_DIRECT  = 2'd3
    } dst_t;

    // Source field, opcode bits 1:0
    typedef enum logic [1:0] {
        SRC_MEM_MAR = 2'd0,
        SRC_ACC     = 2'd1,
        SRC_IMM     = 2'd2,
        SRC_DIRECT  = 2'd3
    } src_t;

    // 16-bit ALU; results wrap
    function automatic logic [15:0] alu_op(fn_t fn, logic [15:0] a, logic [15:0] b);
        logic [15:0] r;
        r = '0;
        case (fn)
            FN_AND:  r = a & b;
            FN_OR:   r = a | b;
            FN_XOR:  r = a ^ b;
            FN_ADD:  r = a + b;
            FN_SUB:  r = a - b;
            FN_INC:  r = a + 16'd1;
            FN_DEC:  r = a - 16'd1;
            default: r = ~a;
        endcase
        return r;
    endfunction

endpackage

@@ design/accumulator_alu_instruction_execute.sv @@
// Top level of the accumulator ALU execute block: byte memory, ACC, MAR and pipeline.
// An accepted item is registered into the execute stage and moves on into the output
// register (m_tvalid high) when that register is free.
// Throughput: one item per cycle while the output is not stalled; no item is accepted
// while an instruction that writes MAR is in execute, as its memory read address comes from MAR.
// Memory has two registered read ports (MAR and direct/access address) and one write port.
// Reset clears ACC, MAR and the valid flags; the byte memory is not cleared.
module accumulator_alu_instruction_execute
    import aaie_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // opcode[7:0], first_byte[15:8], second_byte[23:16], access_address[39:24],
    // write_data[47:40]
    input  logic [S_DATA_BITS-1:0] s_tdata,
    // mode[1:0]
    input  logic [S_USER_BITS-1:0] s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // acc_value[7:0], mar_value[23:8], read_data[31:24], bytes_used[33:32],
    // invalid[34], zero[39:35]
    output logic [M_DATA_BITS-1:0] m_tdata
);

    // Byte memory
    logic [7:0] main_mem [MEM_DEPTH];

    // Architectural registers
    logic [7:0]  acc_reg, acc_next;
    logic [15:0] mar_reg, mar_next;

    // Execute stage
    logic        ex_valid_reg;
    logic [1:0]  ex_mode_reg;
    logic [7:0]  ex_op_reg;
    logic [7:0]  ex_b1_reg;
    logic [7:0]  ex_b2_reg;
    addr_t       ex_addr_reg;
    logic [7:0]  ex_wdata_reg;

    // Memory read data and forwarding
    logic [7:0]  rd_a_reg, rd_b_reg;
    logic        fwd_a_reg, fwd_b_reg;
    logic [7:0]  fwd_data_reg;

    // Output register
    logic        out_valid_reg;
    logic [7:0]  out_acc_reg;
    logic [15:0] out_mar_reg;
    logic [7:0]  out_rdata_reg;
    logic [1:0]  out_used_reg;
    logic        out_invalid_reg;

    // Handshake and hazard control
    logic        s_accept;
    logic        ex_advance;
    logic        ex_mar_wr;
    logic [15:0] s_imm16;
    addr_t       addr_a;
    addr_t       addr_b;

    // Execute stage decode and datapath
    fn_t         fn;
    dst_t        dst;
    src_t        src;
    logic        unary;
    logic        is_exec;
    logic        bad;
    logic [15:0] imm16;
    logic [7:0]  mem_a;
    logic [7:0]  mem_b;
    logic [15:0] opnd_a;
    logic [15:0] opnd_b;
    logic [15:0] alu_res;
    logic [1:0]  used;
    logic [7:0]  rdata;
    logic        wr_en;
    addr_t       wr_addr;
    logic [7:0]  wr_data;

    // Control: execute advances when output register is free; MAR write stalls input
    assign ex_advance = ex_valid_reg && (!out_valid_reg || m_tready);
    assign ex_mar_wr  = ex_valid_reg && is_exec && !bad && (dst == DST_MAR);
    assign s_tready   = (!ex_valid_reg || ex_advance) && !ex_mar_wr;
    assign s_accept   = s_tvalid && s_tready;

    // Read addresses for the incoming item
    assign addr_a  = mar_reg[ADDR_BITS-1:0];
    assign s_imm16 = {s_tdata[15:8], s_tdata[23:16]};
    always_comb begin
        if (mode_t'(s_tuser) == MODE_READ) begin
            addr_b = s_tdata[24 +: ADDR_BITS];
        end else begin
            addr_b = s_imm16[ADDR_BITS-1:0];
        end
    end

    // Memory: two registered reads at accept, one write when execute advances
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            main_mem[wr_addr] <= wr_data;
        end
        if (s_accept) begin
            rd_a_reg <= main_mem[addr_a];
            rd_b_reg <= main_mem[addr_b];
        end
    end

    // Forwarding of a write that lands on the same edge as the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end else if (s_accept) begin
            fwd_a_reg <= wr_en && (wr_addr == addr_a);
            fwd_b_reg <= wr_en && (wr_addr == addr_b);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_data_reg <= wr_data;
        end
    end

    // Execute stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
        end else if (s_accept) begin
            ex_valid_reg <= 1'b1;
        end else if (ex_advance) begin
            ex_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ex_mode_reg  <= s_tuser;
            ex_op_reg    <= s_tdata[7:0];
            ex_b1_reg    <= s_tdata[15:8];
            ex_b2_reg    <= s_tdata[23:16];
            ex_addr_reg  <= s_tdata[24 +: ADDR_BITS];
            ex_wdata_reg <= s_tdata[47:40];
        end
    end

    // Decode
    assign fn      = fn_t'(ex_op_reg[6:4]);
    assign dst     = dst_t'(ex_op_reg[3:2]);
    assign src     = src_t'(ex_op_reg[1:0]);
    assign unary   = (fn == FN_INC) || (fn == FN_DEC) || (fn == FN_NOT);
    assign is_exec = (mode_t'(ex_mode_reg) == MODE_EXEC);
    assign bad     = is_exec && !unary && (dst == DST_DIRECT)
                     && ((src == SRC_IMM) || (src == SRC_DIRECT));
    assign imm16   = {ex_b1_reg, ex_b2_reg};
    assign mem_a   = fwd_a_reg ? fwd_data_reg : rd_a_reg;
    assign mem_b   = fwd_b_reg ? fwd_data_reg : rd_b_reg;

    // Operand selection
    always_comb begin
        unique case (dst)
            DST_MEM_MAR: opnd_a = {8'h00, mem_a};
            DST_ACC:     opnd_a = {8'h00, acc_reg};
            DST_MAR:     opnd_a = mar_reg;
            DST_DIRECT:  opnd_a = {8'h00, mem_b};
            default:     opnd_a = '0;
        endcase
        unique case (src)
            SRC_MEM_MAR: opnd_b = {8'h00, mem_a};
            SRC_ACC:     opnd_b = {8'h00, acc_reg};
            SRC_IMM:     opnd_b = (dst == DST_MAR) ? imm16 : {8'h00, ex_b1_reg};
            SRC_DIRECT:  opnd_b = {8'h00, mem_b};
            default:     opnd_b = '0;
        endcase
    end

    assign alu_res = alu_op(fn, opnd_a, opnd_b);

    // Instruction length
    always_comb begin
        used = 2'd0;
        if (is_exec && !bad) begin
            if (dst == DST_DIRECT) begin
                used = 2'd3;
            end else if (unary) begin
                used = 2'd1;
            end else begin
                case (src)
                    SRC_MEM_MAR, SRC_ACC: used = 2'd1;
                    SRC_IMM:              used = (dst == DST_MAR) ? 2'd3 : 2'd2;
                    default:              used = 2'd3;
                endcase
            end
        end
    end

    // Write-back selection
    always_comb begin
        acc_next = acc_reg;
        mar_next = mar_reg;
        wr_en    = 1'b0;
        wr_addr  = ex_addr_reg;
        wr_data  = ex_wdata_reg;
        rdata    = 8'h00;
        unique case (mode_t'(ex_mode_reg))
            MODE_EXEC: begin
                if (!bad) begin
                    unique case (dst)
                        DST_MEM_MAR: begin
                            wr_en   = ex_advance;
                            wr_addr = mar_reg[ADDR_BITS-1:0];
                            wr_data = alu_res[7:0];
                        end
                        DST_ACC: acc_next = alu_res[7:0];
                        DST_MAR: mar_next = alu_res;
                        DST_DIRECT: begin
                            wr_en   = ex_advance;
                            wr_addr = imm16[ADDR_BITS-1:0];
                            wr_data = alu_res[7:0];
                        end
                        default: ;
                    endcase
                end
            end
            MODE_WRITE: wr_en = ex_advance;
            MODE_READ:  rdata = mem_b;
            default: ;
        endcase
    end

    // Architectural registers update as the item leaves execute
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            mar_reg <= '0;
        end else if (ex_advance) begin
            acc_reg <= acc_next;
            mar_reg <= mar_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ex_advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_advance) begin
            out_acc_reg     <= acc_next;
            out_mar_reg     <= mar_next;
            out_rdata_reg   <= rdata;
            out_used_reg    <= used;
            out_invalid_reg <= bad;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_invalid_reg, out_used_reg, out_rdata_reg,
                       out_mar_reg, out_acc_reg};

    // Checks
    a_mar_interlock: assert property (@(posedge aclk) disable iff (!aresetn)
        ex_mar_wr |-> !s_accept)
        else $error("item accepted while MAR write pending");

    a_invalid_len: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_invalid_reg |-> out_used_reg == 2'd0)
        else $error("invalid instruction reports a length");

    a_accept_fills_ex: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> ex_valid_reg)
        else $error("accepted item missing from execute stage");

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ex_advance |=> out_valid_reg)
        else $error("executed item missing from output register");

    a_fwd_needs_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !wr_en |=> !fwd_a_reg && !fwd_b_reg)
        else $error("forwarding flagged without a write");

endmodule

@@ sim/tb_accumulator_alu_instruction_execute.sv @@
// Self-checking testbench for the accumulator ALU execute block over its item streams.
module tb_accumulator_alu_instruction_execute
    import aaie_pkg::*;
();

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 700;
    localparam int CALM_FROM = 600;
    localparam int HOLD_AT = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;

    // One input item, fields as the block sees them
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  opcode;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [15:0] access_address;
        logic [7:0]  write_data;
    } s_item_t;

    localparam int S_ITEM_BITS = $bits(s_item_t);

    // Machine state and side outputs after one item
    typedef struct packed {
        logic        invalid;
        logic [1:0]  used;
        logic [7:0]  rdata;
        logic [15:0] mar;
        logic [7:0]  acc;
    } m_item_t;

    // Tracks ACC, MAR and the written bytes; queues the state each item should leave behind
    class acc_machine_sb;
        logic [7:0]  acc;
        logic [15:0] mar;
        logic [7:0]  mem_bytes [logic [15:0]];
        m_item_t     expected_states [$];
        int          errors;

        function new();
            acc = '0;
            mar = '0;
            errors = 0;
        endfunction

        function bit is_written(logic [15:0] a);
            return mem_bytes.exists(a);
        endfunction

        function logic [7:0] mem_rd(logic [15:0] a);
            return mem_bytes.exists(a) ? mem_bytes[a] : 8'h00;
        endfunction

        // Two-operand function with a direct destination and an immediate or direct source
        function bit is_invalid(s_item_t it);
            fn_t  fn;
            dst_t dst;
            src_t src;
            fn  = fn_t'(it.opcode[6:4]);
            dst = dst_t'(it.opcode[3:2]);
            src = src_t'(it.opcode[1:0]);
            return (fn != FN_INC) && (fn != FN_DEC) && (fn != FN_NOT) &&
                   (dst == DST_DIRECT) && ((src == SRC_IMM) || (src == SRC_DIRECT));
        endfunction

        // Memory bytes an item reads, given the current MAR
        function void reads_of(s_item_t it, ref logic [15:0] addrs [$]);
            fn_t  fn;
            dst_t dst;
            src_t src;
            fn  = fn_t'(it.opcode[6:4]);
            dst = dst_t'(it.opcode[3:2]);
            src = src_t'(it.opcode[1:0]);
            addrs.delete();
            if (it.mode == MODE_READ) begin
                addrs.push_back(it.access_address);
            end else if (it.mode == MODE_EXEC && !is_invalid(it)) begin
                if (dst == DST_MEM_MAR) addrs.push_back(mar);
                if (dst == DST_DIRECT) addrs.push_back({it.first_byte, it.second_byte});
                if ((fn != FN_INC) && (fn != FN_DEC) && (fn != FN_NOT)) begin
                    if (src == SRC_MEM_MAR) addrs.push_back(mar);
                    if (src == SRC_DIRECT) addrs.push_back({it.first_byte, it.second_byte});
                end
            end
        endfunction

        function logic [15:0] alu16(fn_t fn, logic [15:0] a, logic [15:0] b);
            case (fn)
                FN_AND:  return a & b;
                FN_OR:   return a | b;
                FN_XOR:  return a ^ b;
                FN_ADD:  return a + b;
                FN_SUB:  return a - b;
                FN_INC:  return a + 16'd1;
                FN_DEC:  return a - 16'd1;
                default: return ~a;
            endcase
        endfunction

        // Apply one accepted item to the state and queue the result it should give
        function void note_accepted(s_item_t it);
            m_item_t     r;
            fn_t         fn;
            dst_t        dst;
            src_t        src;
            logic [15:0] imm16;
            logic [15:0] a;
            logic [15:0] b;
            logic [15:0] res;
            r     = '0;
            fn    = fn_t'(it.opcode[6:4]);
            dst   = dst_t'(it.opcode[3:2]);
            src   = src_t'(it.opcode[1:0]);
            imm16 = {it.first_byte, it.second_byte};
            case (it.mode)
                MODE_WRITE: mem_bytes[it.access_address] = it.write_data;
                MODE_READ:  r.rdata = mem_rd(it.access_address);
                MODE_EXEC: begin
                    if (is_invalid(it)) begin
                        r.invalid = 1'b1;
                    end else begin
                        case (dst)
                            DST_MEM_MAR: a = {8'h00, mem_rd(mar)};
                            DST_ACC:     a = {8'h00, acc};
                            DST_MAR:     a = mar;
                            default:     a = {8'h00, mem_rd(imm16)};
                        endcase
                        b = '0;
                        if ((fn == FN_INC) || (fn == FN_DEC) || (fn == FN_NOT)) begin
                            r.used = (dst == DST_DIRECT) ? 2'd3 : 2'd1;
                        end else begin
                            case (src)
                                SRC_MEM_MAR: begin
                                    b = {8'h00, mem_rd(mar)};
                                    r.used = 2'd1;
                                end
                                SRC_ACC: begin
                                    b = {8'h00, acc};
                                    r.used = 2'd1;
                                end
                                SRC_IMM: begin
                                    // MAR takes the full 16-bit immediate
                                    if (dst == DST_MAR) begin
                                        b = imm16;
                                        r.used = 2'd3;
                                    end else begin
                                        b = {8'h00, it.first_byte};
                                        r.used = 2'd2;
                                    end
                                end
                                default: begin
                                    b = {8'h00, mem_rd(imm16)};
                                    r.used = 2'd3;
                                end
                            endcase
                            if (dst == DST_DIRECT) r.used = 2'd3;
                        end
                        res = alu16(fn, a, b);
                        case (dst)
                            DST_MEM_MAR: mem_bytes[mar] = res[7:0];
                            DST_ACC:     acc = res[7:0];
                            DST_MAR:     mar = res;
                            default:     mem_bytes[imm16] = res[7:0];
                        endcase
                    end
                end
                default: ;
            endcase
            r.acc = acc;
            r.mar = mar;
            expected_states.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp, act);
                errors++;
            end
        endfunction

        // Check one accepted result against the oldest expected state
        function void check_result(logic [M_DATA_BITS-1:0] d);
            m_item_t e;
            if (expected_states.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0h", $time, d);
                errors++;
                return;
            end
            e = expected_states.pop_front();
            compare_field("acc_value", 32'(e.acc), 32'(d[7:0]));
            compare_field("mar_value", 32'(e.mar), 32'(d[23:8]));
            compare_field("read_data", 32'(e.rdata), 32'(d[31:24]));
            compare_field("bytes_used", 32'(e.used), 32'(d[33:32]));
            compare_field("invalid", 32'(e.invalid), 32'(d[34]));
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata;
    logic [S_USER_BITS-1:0] s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_BITS-1:0] m_tdata;

    acc_machine_sb sb = new();
    bit            calm = 1'b0;
    bit            hold_request = 1'b0;
    int            cycles = 0;

    accumulator_alu_instruction_execute dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_accumulator_alu_instruction_execute: errors");
            $finish;
        end
    end

    // Offer one item, wait for the handshake, then update the prediction
    task automatic drive_item(s_item_t it);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {it.write_data, it.access_address, it.second_byte, it.first_byte,
                     it.opcode};
        do @(posedge aclk); while (!s_tready);
        sb.note_accepted(it);
    endtask

    // Write any byte the item would read before it has been written, then send it
    task automatic send_item(s_item_t it);
        logic [15:0] addrs [$];
        s_item_t     w;
        sb.reads_of(it, addrs);
        foreach (addrs[i]) begin
            if (!sb.is_written(addrs[i])) begin
                w = s_item_t'(S_ITEM_BITS'({$urandom, $urandom}));
                w.mode = MODE_WRITE;
                w.access_address = addrs[i];
                drive_item(w);
            end
        end
        drive_item(it);
    endtask

    function automatic s_item_t make_item(logic [1:0] mode, logic [7:0] op, logic [7:0] b1,
                                          logic [7:0] b2, logic [15:0] addr, logic [7:0] wd);
        s_item_t it;
        it.mode           = mode;
        it.opcode         = op;
        it.first_byte     = b1;
        it.second_byte    = b2;
        it.access_address = addr;
        it.write_data     = wd;
        return it;
    endfunction

    // Addresses clustered at both ends of memory and at MAR, so bytes get reused; one choice in four is random
    function automatic logic [15:0] pick_addr();
        case ($urandom_range(0, 3))
            0:       return {12'h000, 4'($urandom)};
            1:       return {12'hFFF, 4'($urandom)};
            2:       return sb.mar;
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: checks results, stalls in bursts, and once holds off for a long stretch
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Sender and run control
    initial begin
        s_item_t     it;
        logic [15:0] pair;
        int          pick;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: memory ends, every dst/src pair, every function, invalid forms, unused mode
        send_item(make_item(MODE_WRITE, 8'h00, 8'h00, 8'h00, 16'h0000, 8'hFF));
        send_item(make_item(MODE_WRITE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'h00));
        send_item(make_item(MODE_READ, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00));
        send_item(make_item(MODE_READ, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF));
        for (int i = 0; i < 16; i++) begin
            send_item(make_item(MODE_EXEC, {i[0], i[2:0], i[3:2], i[1:0]},
                                i[0] ? 8'hFF : 8'h00, i[1] ? 8'hFF : 8'h00,
                                16'($urandom), 8'($urandom)));
        end
        send_item(make_item(MODE_EXEC, {1'b0, FN_ADD, DST_DIRECT, SRC_IMM},
                            8'h12, 8'h34, 16'h0000, 8'h00));
        send_item(make_item(MODE_EXEC, {1'b1, FN_SUB, DST_DIRECT, SRC_DIRECT},
                            8'hFF, 8'hFF, 16'hFFFF, 8'hFF));
        send_item(make_item(MODE_EXEC, {1'b0, FN_ADD, DST_MAR, SRC_IMM},
                            8'hFF, 8'hFF, 16'h0000, 8'h00));
        send_item(make_item(MODE_EXEC, {1'b0, FN_INC, DST_MAR, SRC_ACC},
                            8'h00, 8'h00, 16'h0000, 8'h00));
        send_item(make_item(MODE_EXEC, {1'b0, FN_SUB, DST_ACC, SRC_IMM},
                            8'hFF, 8'h00, 16'h0000, 8'h00));
        send_item(make_item(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF));

        // Random items; the receiver gets one long hold-off, the tail runs without gaps
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT) hold_request = 1'b1;
            if (n == CALM_FROM) calm = 1'b1;
            it = s_item_t'(S_ITEM_BITS'({$urandom, $urandom}));
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                it.mode = MODE_EXEC;
                if ($urandom_range(0, 1) == 0) begin
                    pair = pick_addr();
                    it.first_byte  = pair[15:8];
                    it.second_byte = pair[7:0];
                end
            end else if (pick < 75) begin
                it.mode = MODE_WRITE;
                if ($urandom_range(0, 3) != 0) it.access_address = pick_addr();
            end else if (pick < 95) begin
                it.mode = MODE_READ;
                if ($urandom_range(0, 3) != 0) it.access_address = pick_addr();
            end else begin
                it.mode = MODE_UNUSED;
            end
            send_item(it);
        end
        s_tvalid <= 1'b0;

        // Drain and let any stray result show up
        while (sb.expected_states.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb_accumulator_alu_instruction_execute: clean");
        end else begin
            $display("tb_accumulator_alu_instruction_execute: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/aaie_pkg.sv
design/accumulator_alu_instruction_execute.sv
sim/tb_accumulator_alu_instruction_execute.sv
